[sv/assert_macros.svh]
// Assertion macros used by the modulator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/fpvm_pkg.sv]
// Shared types and constants of the phase voltage modulator.
package fpvm_pkg;

   localparam int VS_BITS    = 6;
   localparam int VOLT_SHIFT = 38;
   localparam int U_BITS     = 48;

   // register indexes of the configuration port
   localparam logic CSR_DRIVER_MODE  = 1'b0;
   localparam logic CSR_SUPPLY_VOLTS = 1'b1;

   // sine polynomial coefficients, Q15
   localparam logic [15:0] SIN_A = 16'd51472;
   localparam logic [15:0] SIN_B = 16'd21024;
   localparam logic [11:0] SIN_C = 12'd2320;
   localparam logic [16:0] SIN_CAP = 17'd32768;

   // transform constants, Q15, as positive signed factors
   localparam logic signed [16:0] K_SQRT3_2     = 17'sd28378;
   localparam logic signed [16:0] K_INV_SQRT3   = 17'sd18919;
   localparam logic signed [16:0] K_2_INV_SQRT3 = 17'sd37837;

   typedef enum logic [1:0] {
      SEC_LOW,
      SEC_MID,
      SEC_HIGH
   } sector_type;

   typedef struct packed {
      logic                unipolar;
      logic [VS_BITS-1:0]  vs;
   } cfg_type;

endpackage

[sv/fpvm_sine.sv]
// Four-stage pipelined Q15 sine polynomial on a folded quarter-turn argument.
module fpvm_sine (
   input  logic               clock,
   input  logic [15:0]        t,
   input  logic               neg,
   output logic signed [16:0] sine
);

   logic [15:0] t1_ff, t2a_ff, t2b_ff, t3_ff, t2_1_ff, u1_ff, u2_ff;
   logic        neg1_ff, neg2_ff, neg3_ff;
   logic signed [16:0] sine_ff;

   logic [31:0] sq_in, p2_in, p3_in;
   logic [27:0] p1_in;
   logic [16:0] mag_in;

   always_comb begin
      sq_in  = 32'(t) * 32'(t);
      p1_in  = 28'(fpvm_pkg::SIN_C) * 28'(t2_1_ff);
      p2_in  = 32'(u1_ff) * 32'(t2a_ff);
      p3_in  = 32'(u2_ff) * 32'(t3_ff);
      mag_in = (p3_in[31:15] > fpvm_pkg::SIN_CAP) ? fpvm_pkg::SIN_CAP : p3_in[31:15];
   end

   always_ff @(posedge clock) begin
      // t^2
      t2_1_ff <= sq_in[30:15];
      t1_ff   <= t;
      neg1_ff <= neg;
      // B - C*t^2
      u1_ff   <= fpvm_pkg::SIN_B - 16'(p1_in[27:15]);
      t2a_ff  <= t2_1_ff;
      t2b_ff  <= t1_ff;
      neg2_ff <= neg1_ff;
      // A - t^2*(...)
      u2_ff   <= fpvm_pkg::SIN_A - 16'(p2_in[31:15]);
      t3_ff   <= t2b_ff;
      neg3_ff <= neg2_ff;
      // t*(...)
      sine_ff <= neg3_ff ? -$signed(mag_in) : $signed(mag_in);
   end

   assign sine = sine_ff;

endmodule

[sv/fpvm_duty.sv]
// Phase voltage to duty: offset (bipolar mode only), scale, then a pipelined divide by the supply.
module fpvm_duty #(
   parameter int DUTY_BITS = 8
) (
   input  logic                                 clock,
   input  logic signed [fpvm_pkg::U_BITS-1:0]   volt,
   input  fpvm_pkg::cfg_type                    cfg,
   output logic [DUTY_BITS-1:0]                 duty
);

   localparam int UB = fpvm_pkg::U_BITS;
   localparam int NW = UB + DUTY_BITS;
   localparam int MW = NW - fpvm_pkg::VOLT_SHIFT;
   localparam int VB = fpvm_pkg::VS_BITS;

   logic signed [UB-1:0] full_in, p_in;
   logic [UB-1:0]        pu_in;
   logic [NW-1:0]        n_in;
   logic [MW-1:0]        m_in;
   logic                 sat_in;

   logic [VB-1:0]        rem_ff [0:DUTY_BITS];
   logic [DUTY_BITS-1:0] mlo_ff [0:DUTY_BITS];
   logic [DUTY_BITS-1:0] q_ff   [0:DUTY_BITS];
   logic                 sat_ff [0:DUTY_BITS];
   logic [VB-1:0]        vs_ff  [0:DUTY_BITS];

   always_comb begin
      full_in = $signed(UB'(cfg.vs) << fpvm_pkg::VOLT_SHIFT);
      p_in    = cfg.unipolar ? volt : volt + full_in;
      pu_in   = p_in[UB-1] ? '0 : UB'(p_in);
      // p * (2^D - 1) without a multiplier
      n_in    = (NW'(pu_in) << DUTY_BITS) - NW'(pu_in);
      m_in    = cfg.unipolar ? MW'(n_in >> fpvm_pkg::VOLT_SHIFT)
                             : MW'(n_in >> (fpvm_pkg::VOLT_SHIFT + 1));
      sat_in  = m_in[MW-1:DUTY_BITS] >= (MW-DUTY_BITS)'(cfg.vs);
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= sat_in ? '0 : m_in[DUTY_BITS+VB-1:DUTY_BITS];
      mlo_ff[0] <= m_in[DUTY_BITS-1:0];
      q_ff[0]   <= '0;
      sat_ff[0] <= sat_in;
      vs_ff[0]  <= cfg.vs;
   end

   // one quotient bit per stage, MSB first
   for (genvar k = 0; k < DUTY_BITS; k++) begin : g_div
      logic [VB:0]   cand_in;
      logic          ge_in;
      logic [VB-1:0] rem_in;

      always_comb begin
         cand_in = {rem_ff[k], mlo_ff[k][DUTY_BITS-1-k]};
         ge_in   = cand_in >= {1'b0, vs_ff[k]};
         rem_in  = ge_in ? VB'(cand_in - {1'b0, vs_ff[k]}) : cand_in[VB-1:0];
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= rem_in;
         mlo_ff[k+1] <= mlo_ff[k];
         q_ff[k+1]   <= {q_ff[k][DUTY_BITS-2:0], ge_in};
         sat_ff[k+1] <= sat_ff[k];
         vs_ff[k+1]  <= vs_ff[k];
      end
   end

   assign duty = sat_ff[DUTY_BITS] ? '1 : q_ff[DUTY_BITS];

endmodule

[sv/foc_phase_voltage_modulator.sv]
// Top level of the pipelined sinusoidal phase voltage modulator.
//
// Use: drive req_uq_voltage (signed Q8.8 volts) and req_elec_angle (fraction
// of a turn) with start high; busy is always low, so a beat is taken on every
// cycle that start is high. Each beat yields one result: rsp_strobe is high
// for one cycle with rsp_duty_a/b/c, in input order.
// Throughput: one beat per cycle, set by the fully pipelined datapath: input
// fold, four sine polynomial stages, amplitude multiply, transform multiply,
// phase sum, scaling, then one stage per duty bit of the restoring divide by
// the supply voltage, and an output register.
// Configuration: csr_we writes csr_wdata to register csr_index (0 driver
// mode, 1 supply volts) in the same cycle; write only while no beat is in
// flight. A supply of zero is treated as one volt.
// Reset: synchronous, clears the registers to bipolar mode and 12 V and
// drops every beat in flight. The receiver cannot stall: each result is
// shown for exactly one cycle.
`include "assert_macros.svh"

module foc_phase_voltage_modulator #(
   parameter int ANGLE_BITS = 16,
   parameter int DUTY_BITS  = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [15:0]                  req_uq_voltage,
   input  logic [ANGLE_BITS-1:0]               req_elec_angle,
   output logic                                rsp_strobe,
   output logic [DUTY_BITS-1:0]                rsp_duty_a,
   output logic [DUTY_BITS-1:0]                rsp_duty_b,
   output logic [DUTY_BITS-1:0]                rsp_duty_c,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [fpvm_pkg::VS_BITS-1:0]        csr_wdata
);

   localparam int LAT = 10 + DUTY_BITS;
   localparam int AB  = ANGLE_BITS;
   localparam int UB  = fpvm_pkg::U_BITS;
   localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);
   localparam logic [AB-1:0] HALF    = AB'(1) << (AB - 1);
   localparam logic [AB+1:0] TURN    = (AB+2)'(1) << AB;

   logic                         mode_ff;
   logic [fpvm_pkg::VS_BITS-1:0] vs_ff;
   fpvm_pkg::cfg_type            cfg;
   logic [LAT-1:0]               vld_ff;

   // stage 1 inputs
   logic          nonpos_in;
   logic [15:0]   mag_in;
   logic [AB-1:0] th_in, thc_in;
   logic [AB+1:0] th3_in;
   logic [16:0]   fs_in, fc_in;
   fpvm_pkg::sector_type sec_in;

   logic [15:0]   mag_ff [0:4];
   fpvm_pkg::sector_type sec_ff [0:6];
   logic [15:0]   ts_ff, tc_ff;
   logic          negs_ff, negc_ff;

   logic signed [16:0] sin_w, cos_w;
   logic signed [33:0] alp_in, bep_in;
   logic signed [31:0] al_ff, be_ff, al7_ff;
   logic signed [48:0] b28_in, b19_in, b38_in;
   logic signed [UB-1:0] b28_ff, b19_ff, b38_ff;
   logic signed [UB-1:0] al_x, ua_in, ub_in, uc_in, ua_ff, ub_ff, uc_ff;
   logic [DUTY_BITS-1:0] da_w, db_w, dc_w;

   // fold a phase into {negate, Q15 quarter-turn argument}
   function automatic logic [16:0] fold(input logic [AB-1:0] ph);
      logic [1:0]     quad;
      logic [AB-2:0]  x;
      logic [AB+13:0] wide;
      quad = ph[AB-1:AB-2];
      x    = {1'b0, ph[AB-3:0]};
      if (quad[0]) begin
         x = (AB-1)'(QUARTER) - x;
      end
      wide = (AB+14)'(x) << 15;
      wide = wide >> (AB - 2);
      return {quad[1], wide[15:0]};
   endfunction

   assign busy = 1'b0;
   assign cfg  = '{unipolar: mode_ff, vs: (vs_ff == '0) ? 6'd1 : vs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         vs_ff   <= 6'd12;
         vld_ff  <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               fpvm_pkg::CSR_DRIVER_MODE:  mode_ff <= csr_wdata[0];
               fpvm_pkg::CSR_SUPPLY_VOLTS: vs_ff   <= csr_wdata;
               default: ;
            endcase
         end
         vld_ff <= {vld_ff[LAT-2:0], start && !busy};
      end
   end

   always_comb begin
      nonpos_in = req_uq_voltage[15] || (req_uq_voltage == 16'sd0);
      mag_in    = req_uq_voltage[15] ? 16'(-req_uq_voltage) : 16'(req_uq_voltage);
      th_in     = req_elec_angle + (mode_ff ? '0 : QUARTER) + (nonpos_in ? HALF : '0);
      thc_in    = th_in + QUARTER;
      fs_in     = fold(th_in);
      fc_in     = fold(thc_in);
      th3_in    = (AB+2)'(th_in) * (AB+2)'(3);
      if (th3_in <= TURN) begin
         sec_in = fpvm_pkg::SEC_LOW;
      end else if (th3_in <= (TURN << 1)) begin
         sec_in = fpvm_pkg::SEC_MID;
      end else begin
         sec_in = fpvm_pkg::SEC_HIGH;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff[0] <= mag_in;
      sec_ff[0] <= sec_in;
      ts_ff     <= fs_in[15:0];
      negs_ff   <= fs_in[16];
      tc_ff     <= fc_in[15:0];
      negc_ff   <= fc_in[16];
      for (int i = 0; i < 4; i++) begin
         mag_ff[i+1] <= mag_ff[i];
      end
      for (int i = 0; i < 6; i++) begin
         sec_ff[i+1] <= sec_ff[i];
      end
   end

   fpvm_sine u_sin (.clock(clock), .t(ts_ff), .neg(negs_ff), .sine(sin_w));
   fpvm_sine u_cos (.clock(clock), .t(tc_ff), .neg(negc_ff), .sine(cos_w));

   always_comb begin
      alp_in = $signed({1'b0, mag_ff[4]}) * cos_w;
      bep_in = $signed({1'b0, mag_ff[4]}) * sin_w;
      b28_in = be_ff * fpvm_pkg::K_SQRT3_2;
      b19_in = be_ff * fpvm_pkg::K_INV_SQRT3;
      b38_in = be_ff * fpvm_pkg::K_2_INV_SQRT3;
   end

   always_ff @(posedge clock) begin
      al_ff  <= alp_in[31:0];
      be_ff  <= bep_in[31:0];
      al7_ff <= al_ff;
      b28_ff <= b28_in[UB-1:0];
      b19_ff <= b19_in[UB-1:0];
      b38_ff <= b38_in[UB-1:0];
   end

   // inverse Clarke, or sector mapping with one phase grounded
   always_comb begin
      al_x = UB'(al7_ff);
      if (!mode_ff) begin
         ua_in = al_x <<< 15;
         ub_in = -(al_x <<< 14) + b28_ff;
         uc_in = -(al_x <<< 14) - b28_ff;
      end else begin
         unique case (sec_ff[6])
            fpvm_pkg::SEC_LOW: begin
               ua_in = (al_x <<< 15) + b19_ff;
               ub_in = b38_ff;
               uc_in = '0;
            end
            fpvm_pkg::SEC_MID: begin
               ua_in = '0;
               ub_in = b19_ff - (al_x <<< 15);
               uc_in = -b19_ff - (al_x <<< 15);
            end
            default: begin
               ua_in = (al_x <<< 15) - b19_ff;
               ub_in = '0;
               uc_in = -b38_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      ua_ff <= ua_in;
      ub_ff <= ub_in;
      uc_ff <= uc_in;
   end

   fpvm_duty #(.DUTY_BITS(DUTY_BITS)) u_duty_a (
      .clock(clock), .volt(ua_ff), .cfg(cfg), .duty(da_w));
   fpvm_duty #(.DUTY_BITS(DUTY_BITS)) u_duty_b (
      .clock(clock), .volt(ub_ff), .cfg(cfg), .duty(db_w));
   fpvm_duty #(.DUTY_BITS(DUTY_BITS)) u_duty_c (
      .clock(clock), .volt(uc_ff), .cfg(cfg), .duty(dc_w));

   always_ff @(posedge clock) begin
      rsp_duty_a <= da_w;
      rsp_duty_b <= db_w;
      rsp_duty_c <= dc_w;
   end

   assign rsp_strobe = vld_ff[LAT-1];

   `ASSERT_IMPLIES(a_strobe_latency, clock, reset, rsp_strobe, $past(start, LAT))
   `ASSERT_NEXT(a_no_spurious, clock, reset, (vld_ff[LAT-2] == 1'b0), !rsp_strobe)

endmodule

[tb/tb_foc_phase_voltage_modulator.sv]
// Testbench for the phase voltage modulator: random and directed beats checked against a predictor.
`timescale 1ns / 100ps

module tb_foc_phase_voltage_modulator;

   localparam int LATENCY = 18;
   localparam longint CYCLE_LIMIT = 200000;

   typedef struct {
      logic signed [15:0] uq;
      logic [15:0]        angle;
      bit                 pause;
   } beat_type;

   typedef struct {
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] c;
   } duty_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_uq_voltage = '0;
   logic [15:0] req_elec_angle = '0;
   logic rsp_strobe;
   logic [7:0] rsp_duty_a, rsp_duty_b, rsp_duty_c;
   logic csr_we = 1'b0;
   logic csr_index = fpvm_pkg::CSR_DRIVER_MODE;
   logic [fpvm_pkg::VS_BITS-1:0] csr_wdata = '0;

   beat_type pending_beats[$];
   duty_type expected_duties[$];
   int error_count = 0;
   longint cycle_count = 0;
   int gap_left = 0;
   int burst_left = 0;
   bit mode_unipolar = 1'b0;
   int supply = 12;

   foc_phase_voltage_modulator u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_uq_voltage(req_uq_voltage), .req_elec_angle(req_elec_angle),
      .rsp_strobe(rsp_strobe), .rsp_duty_a(rsp_duty_a), .rsp_duty_b(rsp_duty_b),
      .rsp_duty_c(rsp_duty_c), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint sine_q15(logic [15:0] ph);
      logic [1:0] quad;
      longint x, t, t2, u, s;
      quad = ph[15:14];
      x = ph[13:0];
      if (quad[0]) x = 16384 - x;
      t = (x << 15) >> 14;
      t2 = (t * t) >> 15;
      u = (2320 * t2) >> 15;
      u = 21024 - u;
      u = (u * t2) >> 15;
      u = 51472 - u;
      s = (u * t) >> 15;
      if (s > 32768) s = 32768;
      return quad[1] ? -s : s;
   endfunction

   function automatic logic [7:0] to_duty(longint num, longint den);
      longint d;
      d = num / den;
      if (d < 0) d = 0;
      if (d > 255) d = 255;
      return d[7:0];
   endfunction

   function automatic duty_type modulate(logic signed [15:0] uq, logic [15:0] angle);
      duty_type r;
      longint mag, vs, full, al, be, ua, ub, uc, th3;
      logic [15:0] th;
      mag = (uq < 0) ? -longint'(uq) : longint'(uq);
      vs = (supply == 0) ? 1 : supply;
      full = vs << fpvm_pkg::VOLT_SHIFT;
      th = angle;
      if (!mode_unipolar) begin
         th = th + 16'h4000;
         if (uq <= 0) th = th + 16'h8000;
         al = mag * sine_q15(th + 16'h4000);
         be = mag * sine_q15(th);
         ua = al * 32768;
         ub = -al * 16384 + be * 28378;
         uc = -al * 16384 - be * 28378;
         r.a = to_duty((ua + full) * 255, 2 * full);
         r.b = to_duty((ub + full) * 255, 2 * full);
         r.c = to_duty((uc + full) * 255, 2 * full);
      end else begin
         if (uq <= 0) th = th + 16'h8000;
         al = mag * sine_q15(th + 16'h4000);
         be = mag * sine_q15(th);
         th3 = 3 * longint'(th);
         if (th3 <= 65536) begin
            ua = al * 32768 + be * 18919;
            ub = be * 37837;
            uc = 0;
         end else if (th3 <= 131072) begin
            ua = 0;
            ub = be * 18919 - al * 32768;
            uc = -be * 18919 - al * 32768;
         end else begin
            ua = al * 32768 - be * 18919;
            ub = 0;
            uc = -be * 37837;
         end
         r.a = to_duty(ua * 255, full);
         r.b = to_duty(ub * 255, full);
         r.c = to_duty(uc * 255, full);
      end
      return r;
   endfunction

   task automatic report(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // driver: bursts with random gaps; a pause beat holds until the pipe drains
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         expected_duties.push_back(modulate(req_uq_voltage, req_elec_angle));
         if (gap_left == 0 && burst_left > 0 && pending_beats.size() > 0
             && !pending_beats[0].pause) begin
            beat_type b;
            b = pending_beats.pop_front();
            req_uq_voltage <= b.uq;
            req_elec_angle <= b.angle;
            burst_left--;
         end else begin
            start <= 1'b0;
         end
      end else if (gap_left > 0) begin
         gap_left--;
      end else if (pending_beats.size() > 0) begin
         if (pending_beats[0].pause) begin
            if (expected_duties.size() == 0) void'(pending_beats.pop_front());
         end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         end else begin
            beat_type b;
            b = pending_beats.pop_front();
            req_uq_voltage <= b.uq;
            req_elec_angle <= b.angle;
            start <= 1'b1;
            burst_left--;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_strobe) begin
         if (expected_duties.size() == 0) begin
            $display("unexpected beat at cycle %0d", cycle_count);
            error_count++;
         end else begin
            duty_type e;
            e = expected_duties.pop_front();
            if (rsp_duty_a !== e.a) report("duty_a", rsp_duty_a, e.a);
            if (rsp_duty_b !== e.b) report("duty_b", rsp_duty_b, e.b);
            if (rsp_duty_c !== e.c) report("duty_c", rsp_duty_c, e.c);
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_foc_phase_voltage_modulator: done, errors");
         $finish;
      end
   end

   task automatic queue_beat(int uq, int angle);
      beat_type b;
      b.uq = 16'(uq);
      b.angle = 16'(angle);
      b.pause = 1'b0;
      pending_beats.push_back(b);
   endtask

   task automatic queue_pause();
      beat_type b;
      b.uq = 0;
      b.angle = 0;
      b.pause = 1'b1;
      pending_beats.push_back(b);
   endtask

   task automatic wait_idle();
      while (pending_beats.size() > 0 || start || expected_duties.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // the trailing edge keeps back-to-back writes from setting csr_we twice in one step
   task automatic write_csr(logic idx, int value);
      csr_index <= idx;
      csr_wdata <= fpvm_pkg::VS_BITS'(value);
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == fpvm_pkg::CSR_DRIVER_MODE) mode_unipolar = value[0];
      else supply = value;
   endtask

   task automatic queue_random(int count);
      int uq;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: uq = $urandom_range(0, 65535);
            1: uq = $urandom_range(0, 12 * 256) - 6 * 256;
            2: uq = $urandom_range(0, 2) ? 16'h7FFF : 16'h8000;
            default: uq = $urandom_range(0, 512) - 256;
         endcase
         queue_beat(uq, $urandom_range(0, 65535));
      end
   endtask

   initial begin
      int modes[6] = '{0, 1, 0, 1, 0, 1};
      int volts[6] = '{12, 1, 60, 0, 24, 63};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: field extremes, zero request, sector edges
      foreach (modes[p]) begin
         if (p > 0) begin
            write_csr(fpvm_pkg::CSR_DRIVER_MODE, modes[p]);
            write_csr(fpvm_pkg::CSR_SUPPLY_VOLTS, volts[p]);
         end
         if (p < 2) begin
            queue_beat(0, 0);
            queue_beat(16'h7FFF, 16'hFFFF);
            queue_beat(16'h8000, 0);
            queue_beat(-1, 16'h5555);
            queue_beat(1, 16'h5556);
            queue_beat(256, 16'hAAAA);
            queue_beat(256, 16'hAAAB);
            queue_beat(3072, 16'h4000);
            queue_beat(-3072, 16'hC000);
            queue_beat(16'h5A5A, 16'hA5A5);
         end
         queue_random(300);
         queue_pause();
         queue_random(10);
         wait_idle();
      end
      if (error_count == 0) begin
         $display("tb_foc_phase_voltage_modulator: done, clean");
      end else begin
         $display("tb_foc_phase_voltage_modulator: done, errors");
      end
      $finish;
   end

endmodule
